>>> hdl/text_terminal_char_writer_assert.svh
// Assertion macros for the text terminal character writer.
`ifndef TEXT_TERMINAL_CHAR_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_CHAR_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("terminal writer check failed");

// Next-cycle implication, checked outside reset.
`define TTCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("terminal writer check failed");

`endif

>>> hdl/ttcw_pkg.sv
// Shared constants and types for the text terminal character writer.
package ttcw_pkg;

  localparam int COLS_DEFAULT = 40;
  localparam int ROWS_DEFAULT = 24;

  // Field widths of the stream payloads
  localparam int CHAR_W    = 8;
  localparam int ROW_FW    = 5;
  localparam int COL_FW    = 6;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  // Request kinds carried in s_tuser
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_CR         = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_LOW_LIMIT  = 8'h1F;
  localparam logic [CHAR_W-1:0] CODE_HIGH_LIMIT = 8'h60;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_ADDR,
    ST_CLEAR,
    ST_WRITE,
    ST_MEMRD,
    ST_DONE
  } state_t;

endpackage

>>> hdl/text_terminal_char_writer.sv
// Top level of the text terminal character writer: cursor control and cell store.

// Character-cell terminal of COLS x ROWS cells. Each input transfer is either a
// put (s_tuser = 0) or a one-cell read (s_tuser = 1), and each gives exactly one
// output transfer with the cell read and the cursor after the item. Printable
// codes 0x20..0x5F are stored at the cursor, carriage return moves to column 0
// of the next row, other codes change nothing. Leaving the bottom row scrolls
// the screen by advancing a circular top-row pointer. Flow: the block takes
// one item at a time; a carriage return, an ignored code or an out-of-range
// read goes from calc straight to done, an in-range read through address and
// memory read, a stored character through address and write, with a row sweep
// before the write for the first character stored into a row that is blank
// (after reset or after it scrolled in), because that row is swept to zero one
// cell a cycle through the single write port of the cell memory. While the
// previous result transfer is still held by a stalled receiver, the block
// waits in its last state. It returns to idle before the next one is taken.
// Blank rows are tracked by one flag per row, so reset and scroll need no
// clearing pass of their own. The wrapped row arithmetic (logical to physical
// row, top-row advance) goes through one shared modular adder.
module text_terminal_char_writer
  import ttcw_pkg::*;
#(
  parameter int COLS = COLS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [7:0] char_code, [12:8] read_row, [18:13] read_col, [23:19] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [0] req_type
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [7:0] cell_char, [13:8] cursor_col, [18:14] cursor_row,
  // [19] char_stored, [20] scrolled, [23:21] zero
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = COLS * ROWS;
  localparam int AW    = $clog2(DEPTH);

  state_t state, state_next;

  // Latched request
  logic              req_q;
  logic [CHAR_W-1:0] code_q;
  logic [ROW_FW-1:0] rrow_q;
  logic [COL_FW-1:0] rcol_q;

  // Terminal state
  logic [CW-1:0]   cur_col;
  logic [RW-1:0]   cur_row;
  logic [RW-1:0]   top_row;
  logic [ROWS-1:0] row_valid;

  // Work registers
  logic          read_ok_q;
  logic [RW-1:0] prow_q;
  logic [AW-1:0] base_q;
  logic [AW-1:0] addr_q;
  logic [CW-1:0] cnt;
  logic          stored_q;
  logic          scrolled_q;

  // Cell memory
  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [CHAR_W-1:0] mem_wdata;

  logic is_cr, is_print, read_ok, at_bottom, last_col;
  logic [RW-1:0]   mod_b;
  logic [RW:0]     mod_sum;
  logic [RW-1:0]   mod_out;
  logic [AW-1:0]   base;
  logic [CHAR_W-1:0] cell_rd;
  logic            out_load;

  assign is_cr     = (code_q == CODE_CR);
  assign is_print  = (code_q > CODE_LOW_LIMIT) && (code_q < CODE_HIGH_LIMIT);
  assign read_ok   = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLS);
  assign at_bottom = (cur_row == RW'(ROWS - 1));
  assign last_col  = (cur_col == CW'(COLS - 1));

  // Shared modular adder: top_row + operand, wrapped at ROWS.
  // Operand is the logical row for an address, or one for a scroll.
  always_comb begin
    if (state == ST_CALC && req_q == REQ_READ) begin
      mod_b = RW'(rrow_q);
    end else if (state == ST_CALC && !is_cr) begin
      mod_b = cur_row;
    end else begin
      mod_b = RW'(1);
    end
    mod_sum = {1'b0, top_row} + {1'b0, mod_b};
    if (mod_sum >= (RW + 1)'(ROWS)) begin
      mod_out = RW'(mod_sum - (RW + 1)'(ROWS));
    end else begin
      mod_out = RW'(mod_sum);
    end
  end

  assign base = AW'(prow_q) * AW'(COLS);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_CALC;
      ST_CALC: begin
        if (req_q == REQ_READ) begin
          state_next = read_ok ? ST_ADDR : ST_DONE;
        end else begin
          state_next = is_print ? ST_ADDR : ST_DONE;
        end
      end
      ST_ADDR: begin
        if (req_q == REQ_READ) begin
          state_next = ST_MEMRD;
        end else begin
          state_next = row_valid[prow_q] ? ST_WRITE : ST_CLEAR;
        end
      end
      ST_CLEAR: if (cnt == CW'(COLS - 1)) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_DONE;
      ST_MEMRD: state_next = ST_DONE;
      ST_DONE:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = code_q;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = base_q + AW'(cnt);
        mem_wdata = '0;
      end
      ST_WRITE: mem_we = 1'b1;
      ST_DONE:  out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request latch and per-item work registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        req_q      <= s_tuser;
        code_q     <= s_tdata[7:0];
        rrow_q     <= s_tdata[12:8];
        rcol_q     <= s_tdata[18:13];
        stored_q   <= 1'b0;
        scrolled_q <= 1'b0;
      end
      ST_CALC: begin
        prow_q    <= mod_out;
        read_ok_q <= (req_q == REQ_READ) && read_ok;
        if (req_q == REQ_PUT && is_cr) scrolled_q <= at_bottom;
      end
      ST_ADDR: begin
        base_q <= base;
        addr_q <= base + ((req_q == REQ_READ) ? AW'(CW'(rcol_q)) : AW'(cur_col));
        cnt    <= '0;
      end
      ST_CLEAR: cnt <= cnt + CW'(1);
      ST_WRITE: begin
        stored_q   <= 1'b1;
        scrolled_q <= last_col && at_bottom;
      end
      default: ;
    endcase
  end

  // Cursor, top-row pointer and blank-row flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col   <= '0;
      cur_row   <= '0;
      top_row   <= '0;
      row_valid <= '0;
    end else begin
      if ((state == ST_CALC && req_q == REQ_PUT && is_cr) ||
          (state == ST_WRITE && last_col)) begin
        cur_col <= '0;
        if (at_bottom) begin
          // old top row becomes the new bottom row: mark it blank
          row_valid[top_row] <= 1'b0;
          top_row            <= mod_out;
        end else begin
          cur_row <= cur_row + RW'(1);
        end
      end else if (state == ST_WRITE) begin
        cur_col <= cur_col + CW'(1);
      end
      if (state == ST_CLEAR && cnt == CW'(COLS - 1)) row_valid[prow_q] <= 1'b1;
    end
  end

  // Cell memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata <= mem[addr_q];
  end

  // A blank row reads as zero regardless of stale memory contents
  assign cell_rd = (read_ok_q && row_valid[prow_q]) ? rdata : '0;

  // Output register: hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, scrolled_q, stored_q, ROW_FW'(cur_row), COL_FW'(cur_col), cell_rd};
    end
  end

`include "text_terminal_char_writer_assert.svh"

  // An accepted item keeps the block busy in the cycle after it is taken
  `TTCW_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // The cursor never leaves the grid
  `TTCW_ASSERT_NOW(a_cursor_in_grid, 1'b1,
                   (cur_row <= RW'(ROWS - 1)) && (cur_col <= CW'(COLS - 1)))
  // A scroll always leaves the cursor at column zero
  `TTCW_ASSERT_NOW(a_scroll_col_zero, m_tvalid && m_tdata[20], m_tdata[13:8] == '0)
  // The row sweep writes zeros only
  `TTCW_ASSERT_NOW(a_clear_writes_zero, state == ST_CLEAR, mem_we && (mem_wdata == '0))

endmodule
